// ===== rtl/core/ppd_pkg.sv =====
// Shared types and constants for the proportional position drive.
`default_nettype none

package ppd_pkg;

    localparam int POS_W   = 10;
    localparam int PCT_W   = 7;
    localparam int DUTY_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 10;

    // Serial arithmetic widths: 8-bit multiplier operand, 10-bit multiplicand,
    // 18-bit product (255 * 1023 < 2^18), 10-bit divisor.
    localparam int MUL_A_W = 8;
    localparam int MUL_B_W = 10;
    localparam int PROD_W  = 18;
    localparam int DEN_W   = 10;
    localparam int MCNT_W  = $clog2(MUL_A_W);
    localparam int DCNT_W  = $clog2(PROD_W);

    localparam logic [KIND_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] REQ_RAW    = 2'd1;
    localparam logic [KIND_W-1:0] REQ_PCT    = 2'd2;
    localparam logic [KIND_W-1:0] REQ_STOP   = 2'd3;

    localparam logic [CIDX_W-1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PWM_BASE  = 2'd2;

    localparam logic [POS_W-1:0]  RANGE_MIN_RST = 10'd0;
    localparam logic [POS_W-1:0]  RANGE_MAX_RST = 10'd1023;
    localparam logic [DUTY_W-1:0] PWM_BASE_RST  = 8'd128;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [PCT_W-1:0]  PCT_LIMIT = 7'd100;
    localparam logic [DEN_W-1:0]  PCT_DIV   = 10'd100;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [POS_W-1:0]  position_sample;
        logic [POS_W-1:0]  target_position;
        logic [PCT_W-1:0]  target_percent;
    } in_item_t;

    typedef struct packed {
        logic              forward_drive;
        logic              reverse_drive;
        logic [DUTY_W-1:0] pwm_duty;
        logic              target_active;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_HALT,
        ACT_GOAL,
        ACT_DRIVE
    } action_t;

endpackage

`default_nettype wire

// ===== rtl/core/ppd_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module ppd_mul (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [ppd_pkg::MUL_A_W-1:0]  mul_a,
    input  wire  [ppd_pkg::MUL_B_W-1:0]  mul_b,
    output logic                         done,
    output logic [ppd_pkg::PROD_W-1:0]   product
);
    import ppd_pkg::*;

    logic [MUL_A_W-1:0] a_sh_reg;
    logic [PROD_W-1:0]  b_sh_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [MCNT_W-1:0]  cnt_reg;
    logic               run_reg;
    logic               done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(MUL_A_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_sh_reg <= mul_a;
            b_sh_reg <= PROD_W'(mul_b);
            acc_reg  <= '0;
        end else if (run_reg) begin
            if (a_sh_reg[0]) begin
                acc_reg <= acc_reg + b_sh_reg;
            end
            a_sh_reg <= a_sh_reg >> 1;
            b_sh_reg <= b_sh_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ppd_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none

module ppd_div (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire  [ppd_pkg::PROD_W-1:0]  num,
    input  wire  [ppd_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [ppd_pkg::PROD_W-1:0]  quotient
);
    import ppd_pkg::*;

    logic [PROD_W-1:0] num_sh_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb begin
        trial = {rem_reg, num_sh_reg[PROD_W-1]};
        diff  = trial - {1'b0, den};
        fits  = (trial >= {1'b0, den});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(PROD_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below den, so it always fits in DEN_W bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_sh_reg <= num;
            quo_reg    <= '0;
            rem_reg    <= '0;
        end else if (run_reg) begin
            num_sh_reg <= num_sh_reg << 1;
            quo_reg    <= {quo_reg[PROD_W-2:0], fits};
            rem_reg    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/proportional_position_drive_core.sv =====
// Top level of the proportional position drive with deadband.
//
//  channel  dir  handshake              beat contents
//  s_       in   s_valid / s_ready      in_item_t: req_type, sample, raw target, percent
//  m_       out  m_valid / m_ready      out_item_t: fwd, rev, duty, target_active
//  cfg_     in   cfg_valid / cfg_ready  cfg_index (0 min, 1 max, 2 base), cfg_data
//
// Sequencing: one item at a time. Stops, raw targets and samples that need no
// division pass through PREP, FIN, IDLE. Driving samples and percent targets
// pass through PREP, MUL (the multiplier bits, then done), DIV (the quotient
// bits, then done), FIN, IDLE; m_valid is registered out of FIN.
// Reset (aresetn low, synchronous) clears the drive state and loads the
// register defaults. A finished beat waits in FIN while m_ holds the
// previous one; a held m_ beat does not block accepting the next s_ beat.
`default_nettype none

module proportional_position_drive_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire                           aclk,
    input  wire                           aresetn,

    input  wire                           s_valid,
    output logic                          s_ready,
    input  ppd_pkg::in_item_t             s_item,

    output logic                          m_valid,
    input  wire                           m_ready,
    output ppd_pkg::out_item_t            m_item,

    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [ppd_pkg::CIDX_W-1:0]    cfg_index,
    input  wire  [ppd_pkg::CDATA_W-1:0]   cfg_data
);
    import ppd_pkg::*;

    // ---------------- configuration registers ----------------
    logic [POS_W-1:0]  min_reg;
    logic [POS_W-1:0]  max_reg;
    logic [DUTY_W-1:0] base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= RANGE_MIN_RST;
            max_reg  <= RANGE_MAX_RST;
            base_reg <= PWM_BASE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RANGE_MIN: min_reg  <= cfg_data[POS_W-1:0];
                REG_RANGE_MAX: max_reg  <= cfg_data[POS_W-1:0];
                REG_PWM_BASE:  base_reg <= cfg_data[DUTY_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- sample masking ----------------
    // Only the low SAMPLE_BITS bits of the converter word are meaningful.
    logic [POS_W-1:0] sample_in;

    always_comb begin
        for (int i = 0; i < POS_W; i++) begin
            sample_in[i] = (i < SAMPLE_BITS) && s_item.position_sample[i];
        end
    end

    // ---------------- sequencer and item latch ----------------
    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [KIND_W-1:0] kind_reg;
    logic [POS_W-1:0]  sample_reg;
    logic [POS_W-1:0]  rawt_reg;
    logic [PCT_W-1:0]  pct_reg;
    logic              rev_dir_reg, rev_dir_next;
    logic              neg_reg, neg_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    // drive state
    logic [POS_W-1:0]  goal_reg, goal_next;
    logic              goal_valid_reg, goal_valid_next;
    logic              fwd_reg, fwd_next;
    logic              rev_reg, rev_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg;

    // serial units
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  product;
    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  quotient;

    ppd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .done    (mul_done),
        .product (product)
    );

    ppd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (product),
        .den      (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_MUL) && mul_done;

    // ---------------- PREP: classify the beat ----------------
    logic [POS_W:0]    span;       // signed, max - min
    logic              span_neg;
    logic [POS_W:0]    span_mag;
    logic [POS_W-1:0]  delta;
    logic [15:0]       delta_x50;
    logic              in_deadband;
    logic [PCT_W-1:0]  pct_sat;

    always_comb begin
        span      = {1'b0, max_reg} - {1'b0, min_reg};
        span_neg  = span[POS_W];
        span_mag  = span_neg ? ((POS_W+1)'(0) - span) : span;
        delta     = (sample_reg >= goal_reg) ? (sample_reg - goal_reg)
                                             : (goal_reg - sample_reg);
        // 50 = 32 + 16 + 2
        delta_x50 = (16'(delta) << 5) + (16'(delta) << 4) + (16'(delta) << 1);
        in_deadband = (delta_x50 < 16'(span[POS_W-1:0]));
        pct_sat   = (pct_reg > PCT_LIMIT) ? PCT_LIMIT : pct_reg;
    end

    // ---------------- FIN: new levels ----------------
    logic [DUTY_W:0]   duty_sum;
    logic [DUTY_W-1:0] duty_new;
    logic [POS_W+1:0]  q_signed;
    logic [POS_W+1:0]  t_raw;
    logic [POS_W-1:0]  t_clamped;
    logic              out_free;

    always_comb begin
        duty_sum = {1'b0, base_reg} + {1'b0, quotient[DUTY_W-1:0]};
        if ((|quotient[PROD_W-1:DUTY_W]) || duty_sum[DUTY_W]) begin
            duty_new = DUTY_FULL;
        end else begin
            duty_new = duty_sum[DUTY_W-1:0];
        end

        q_signed = neg_reg ? ((POS_W+2)'(0) - (POS_W+2)'(quotient[POS_W-1:0]))
                           : (POS_W+2)'(quotient[POS_W-1:0]);
        t_raw    = (kind_reg == REQ_PCT) ? ((POS_W+2)'(min_reg) + q_signed)
                                         : (POS_W+2)'(rawt_reg);
        // max test first: in an inverted range a target above range_max settles on range_max, any other on range_min
        if ($signed(t_raw) > $signed((POS_W+2)'(max_reg))) begin
            t_clamped = max_reg;
        end else if ($signed(t_raw) < $signed((POS_W+2)'(min_reg))) begin
            t_clamped = min_reg;
        end else begin
            t_clamped = t_raw[POS_W-1:0];
        end

        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        rev_dir_next    = rev_dir_reg;
        neg_next        = neg_reg;
        den_next        = den_reg;
        goal_next       = goal_reg;
        goal_valid_next = goal_valid_reg;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        duty_next       = duty_reg;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        m_valid_next    = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_FIN;
                unique case (kind_reg)
                    REQ_SAMPLE: begin
                        if (!goal_valid_reg) begin
                            act_next = ACT_NONE;
                        end else if (span_neg || (span == '0) || in_deadband) begin
                            act_next = ACT_HALT;
                        end else begin
                            act_next     = ACT_DRIVE;
                            mul_start    = 1'b1;
                            mul_a        = DUTY_FULL - base_reg;
                            mul_b        = delta;
                            den_next     = span[POS_W-1:0];
                            rev_dir_next = (sample_reg < goal_reg);
                            state_next   = ST_MUL;
                        end
                    end
                    REQ_RAW: begin
                        act_next = ACT_GOAL;
                    end
                    REQ_PCT: begin
                        // truncation toward zero: divide the magnitude, then sign
                        act_next   = ACT_GOAL;
                        mul_start  = 1'b1;
                        mul_a      = MUL_A_W'(pct_sat);
                        mul_b      = span_mag[POS_W-1:0];
                        den_next   = PCT_DIV;
                        neg_next   = span_neg;
                        state_next = ST_MUL;
                    end
                    REQ_STOP: begin
                        act_next = ACT_HALT;
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    unique case (act_reg)
                        ACT_NONE: ;
                        ACT_HALT: begin
                            fwd_next        = 1'b0;
                            rev_next        = 1'b0;
                            duty_next       = '0;
                            goal_valid_next = 1'b0;
                            goal_next       = '0;
                        end
                        ACT_GOAL: begin
                            goal_next       = t_clamped;
                            goal_valid_next = 1'b1;
                        end
                        ACT_DRIVE: begin
                            duty_next = duty_new;
                            fwd_next  = !rev_dir_reg;
                            rev_next  = rev_dir_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            act_reg        <= ACT_NONE;
            goal_reg       <= '0;
            goal_valid_reg <= 1'b0;
            fwd_reg        <= 1'b0;
            rev_reg        <= 1'b0;
            duty_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            goal_reg       <= goal_next;
            goal_valid_reg <= goal_valid_next;
            fwd_reg        <= fwd_next;
            rev_reg        <= rev_next;
            duty_reg       <= duty_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rev_dir_reg <= rev_dir_next;
        neg_reg     <= neg_next;
        den_reg     <= den_next;
        if (s_valid && s_ready) begin
            kind_reg   <= s_item.req_type;
            sample_reg <= sample_in;
            rawt_reg   <= s_item.target_position;
            pct_reg    <= s_item.target_percent;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_item_reg.forward_drive <= fwd_next;
            m_item_reg.reverse_drive <= rev_next;
            m_item_reg.pwm_duty      <= duty_next;
            m_item_reg.target_active <= goal_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for proportional_position_drive_core: directed table plus random beats.
`timescale 1ns / 1ps

module tb_top;
    import ppd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;   // long m_ready hold-off
    localparam int SEG_ITEMS    = 150;
    localparam int NUM_SEGS     = 10;
    localparam int TAIL_CYCLES  = 40;    // idle wait after the final drain
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
    localparam out_item_t LEVELS_OFF = '0;

    // one directed row: the beat, plus a typed-in result where it is obvious
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t levels;
    } drive_row_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_item_t           s_item    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_item_t          m_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDATA_W-1:0] cfg_data  = '0;

    // mirror of the block's registers and drive state
    logic [POS_W-1:0]   mir_min;
    logic [POS_W-1:0]   mir_max;
    logic [DUTY_W-1:0]  mir_base;
    logic [POS_W-1:0]   mir_goal;
    logic               mir_goal_on;
    logic               mir_fwd;
    logic               mir_rev;
    logic [DUTY_W-1:0]  mir_duty;

    out_item_t          drive_levels_q[$];
    drive_row_t         dir_rows[$];
    out_item_t          rx_want;

    int                 err_cnt       = 0;
    int                 cycle_cnt     = 0;
    int                 idle_send_pct = 0;
    int                 stall_recv_pct = 0;
    int                 hold_req      = 0;   // bumped by stimulus
    int                 hold_ack      = 0;   // followed by receiver
    int                 hold_left     = 0;

    proportional_position_drive_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Drive levels after one beat; updates the mirrored state.
    function automatic out_item_t next_drive_levels(input in_item_t it);
        int        s, g, span, delta, duty, p, t, lo, hi;
        bit        load_goal;
        bit        halt;
        out_item_t lv;
        lo        = int'(mir_min);
        hi        = int'(mir_max);
        span      = hi - lo;
        load_goal = 1'b0;
        halt      = 1'b0;
        t         = 0;
        case (it.req_type)
            REQ_SAMPLE: begin
                if (mir_goal_on) begin
                    s     = int'(it.position_sample);
                    g     = int'(mir_goal);
                    delta = (s > g) ? s - g : g - s;
                    // deadband, and a zero or negative span, both stop
                    if (span <= 0 || 50 * delta < span) begin
                        halt = 1'b1;
                    end else begin
                        duty = int'(mir_base)
                             + ((int'(DUTY_FULL) - int'(mir_base)) * delta) / span;
                        if (duty > int'(DUTY_FULL)) duty = int'(DUTY_FULL);
                        mir_duty = duty[DUTY_W-1:0];
                        mir_fwd  = (s >= g);
                        mir_rev  = (s < g);
                    end
                end
            end
            REQ_RAW: begin
                t         = int'(it.target_position);
                load_goal = 1'b1;
            end
            REQ_PCT: begin
                p         = (it.target_percent > PCT_LIMIT) ? int'(PCT_LIMIT)
                                                            : int'(it.target_percent);
                t         = lo + (p * span) / int'(PCT_DIV);   // signed, toward zero
                load_goal = 1'b1;
            end
            default: halt = 1'b1;
        endcase
        if (load_goal) begin
            // max test first: in an inverted range a target above range_max lands on range_max, any other on range_min
            if (t > hi) t = hi;
            else if (t < lo) t = lo;
            mir_goal    = t[POS_W-1:0];
            mir_goal_on = 1'b1;
        end
        if (halt) begin
            mir_fwd     = 1'b0;
            mir_rev     = 1'b0;
            mir_duty    = '0;
            mir_goal_on = 1'b0;
            mir_goal    = '0;
        end
        lv.forward_drive = mir_fwd;
        lv.reverse_drive = mir_rev;
        lv.pwm_duty      = mir_duty;
        lv.target_active = mir_goal_on;
        return lv;
    endfunction

    // Random beat, mostly samples, some of them around the current goal.
    function automatic in_item_t random_beat();
        in_item_t it;
        int       r, w, v;
        it.req_type        = KIND_W'($urandom_range(3));
        it.position_sample = POS_W'($urandom_range(1023));
        it.target_position = POS_W'($urandom_range(1023));
        it.target_percent  = PCT_W'($urandom_range(127));
        r = $urandom_range(99);
        if (r < 55) begin
            it.req_type = REQ_SAMPLE;
            if (mir_goal_on) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    // around the deadband edge
                    w = ((mir_max > mir_min) ? (int'(mir_max) - int'(mir_min))
                                             : (int'(mir_min) - int'(mir_max))) / 25 + 3;
                    v = int'(mir_goal) + int'($urandom_range(2 * w)) - w;
                    if (v < 0) v = 0;
                    if (v > 1023) v = 1023;
                    it.position_sample = v[POS_W-1:0];
                end else if (r < 65) begin
                    it.position_sample = $urandom_range(1) ? 10'd1023 : 10'd0;
                end
            end
        end else if (r < 72) begin
            it.req_type = REQ_RAW;
            if ($urandom_range(4) == 0)
                it.target_position = $urandom_range(1) ? 10'd1023 : 10'd0;
        end else if (r < 88) begin
            it.req_type = REQ_PCT;
        end else begin
            it.req_type = REQ_STOP;
        end
        return it;
    endfunction

    task automatic add_row(input logic [KIND_W-1:0] kind, input int sample, input int raw,
                           input int pct, input logic typed, input out_item_t lv);
        drive_row_t row;
        row.item.req_type        = kind;
        row.item.position_sample = POS_W'(sample);
        row.item.target_position = POS_W'(raw);
        row.item.target_percent  = PCT_W'(pct);
        row.typed                = typed;
        row.levels               = lv;
        dir_rows.push_back(row);
    endtask

    // Offer one beat on s_; called just after a rising edge.
    task automatic send_beat(input in_item_t it, input logic typed, input out_item_t lv);
        out_item_t pred;
        while ($urandom_range(99) < idle_send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        pred = next_drive_levels(it);
        drive_levels_q.push_back(typed ? lv : pred);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RANGE_MIN: mir_min  = data[POS_W-1:0];
            REG_RANGE_MAX: mir_max  = data[POS_W-1:0];
            REG_PWM_BASE:  mir_base = data[DUTY_W-1:0];
            default: ;   // beyond the register list: ignored
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (drive_levels_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: checks every m_ beat and plays m_ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (drive_levels_q.size() == 0) begin
                $error("m_ beat with no result pending: %p", m_item);
                err_cnt++;
            end else begin
                rx_want = drive_levels_q.pop_front();
                if (m_item.forward_drive !== rx_want.forward_drive) begin
                    $error("forward_drive: expected %0d, got %0d",
                           rx_want.forward_drive, m_item.forward_drive);
                    err_cnt++;
                end
                if (m_item.reverse_drive !== rx_want.reverse_drive) begin
                    $error("reverse_drive: expected %0d, got %0d",
                           rx_want.reverse_drive, m_item.reverse_drive);
                    err_cnt++;
                end
                if (m_item.pwm_duty !== rx_want.pwm_duty) begin
                    $error("pwm_duty: expected %0d, got %0d",
                           rx_want.pwm_duty, m_item.pwm_duty);
                    err_cnt++;
                end
                if (m_item.target_active !== rx_want.target_active) begin
                    $error("target_active: expected %0d, got %0d",
                           rx_want.target_active, m_item.target_active);
                    err_cnt++;
                end
            end
        end
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_recv_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int        seg, i, lo, hi;
        in_item_t  it;
        mir_min     = RANGE_MIN_RST;
        mir_max     = RANGE_MAX_RST;
        mir_base    = PWM_BASE_RST;
        mir_goal    = '0;
        mir_goal_on = 1'b0;
        mir_fwd     = 1'b0;
        mir_rev     = 1'b0;
        mir_duty    = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows at reset settings (0..1023, base 128).
        add_row(REQ_SAMPLE, 512, 0, 0, 1'b1, LEVELS_OFF);          // no target yet
        add_row(REQ_STOP, 1023, 1023, 127, 1'b1, LEVELS_OFF);
        add_row(REQ_RAW, 0, 1023, 0, 1'b1, out_item_t'{1'b0, 1'b0, 8'd0, 1'b1});
        add_row(REQ_SAMPLE, 0, 0, 0, 1'b1, out_item_t'{1'b0, 1'b1, DUTY_FULL, 1'b1});
        add_row(REQ_SAMPLE, 1023, 0, 0, 1'b1, LEVELS_OFF);        // on target
        add_row(REQ_RAW, 0, 0, 0, 1'b1, out_item_t'{1'b0, 1'b0, 8'd0, 1'b1});
        add_row(REQ_SAMPLE, 1023, 0, 0, 1'b1, out_item_t'{1'b1, 1'b0, DUTY_FULL, 1'b1});
        add_row(REQ_SAMPLE, 10, 0, 0, 1'b0, LEVELS_OFF);          // inside deadband
        add_row(REQ_PCT, 0, 0, 127, 1'b0, LEVELS_OFF);            // clamped to 100
        add_row(REQ_SAMPLE, 500, 0, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_PCT, 0, 0, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_SAMPLE, 21, 0, 0, 1'b0, LEVELS_OFF);          // just outside deadband
        add_row(REQ_SAMPLE, 20, 0, 0, 1'b0, LEVELS_OFF);          // just inside
        add_row(REQ_PCT, 0, 0, 50, 1'b0, LEVELS_OFF);
        add_row(REQ_SAMPLE, 511, 0, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_PCT, 0, 0, 101, 1'b0, LEVELS_OFF);
        add_row(REQ_RAW, 0, 300, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_SAMPLE, 700, 0, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_SAMPLE, 100, 0, 0, 1'b0, LEVELS_OFF);
        add_row(REQ_RAW, 1023, 1023, 127, 1'b0, LEVELS_OFF);
        add_row(REQ_SAMPLE, 1023, 1023, 127, 1'b0, LEVELS_OFF);
        add_row(REQ_STOP, 1023, 1023, 127, 1'b1, LEVELS_OFF);
        add_row(REQ_SAMPLE, 1023, 1023, 127, 1'b1, LEVELS_OFF);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].levels);
        drain();

        // Random segments: settings change only with nothing in flight.
        for (seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg)
                0: begin write_reg(REG_RANGE_MIN, 0);   write_reg(REG_RANGE_MAX, 1023);
                         write_reg(REG_PWM_BASE, 0); end
                1: begin write_reg(REG_RANGE_MIN, 100); write_reg(REG_RANGE_MAX, 900);
                         write_reg(REG_PWM_BASE, 60); end
                2: begin write_reg(REG_RANGE_MIN, 0);   write_reg(REG_RANGE_MAX, 1023);
                         write_reg(REG_PWM_BASE, 10'h3FF); end          // base 255
                3: begin write_reg(REG_RANGE_MIN, 512); write_reg(REG_RANGE_MAX, 512);
                         write_reg(REG_PWM_BASE, 200); end              // zero span
                4: begin write_reg(REG_RANGE_MIN, 700); write_reg(REG_RANGE_MAX, 300);
                         write_reg(REG_PWM_BASE, 90); end               // inverted range
                5: begin write_reg(REG_RANGE_MIN, 0);   write_reg(REG_RANGE_MAX, 1);
                         write_reg(REG_PWM_BASE, 10); end               // tiny span
                6: begin write_reg(REG_RANGE_MIN, 1023); write_reg(REG_RANGE_MAX, 1023);
                         write_reg(REG_PWM_BASE, 255); end
                7: begin
                    lo = $urandom_range(1000);
                    hi = $urandom_range(1023, lo + 1);
                    write_reg(REG_RANGE_MIN, CDATA_W'(lo));
                    write_reg(REG_RANGE_MAX, CDATA_W'(hi));
                    write_reg(REG_PWM_BASE, CDATA_W'($urandom_range(1023)));
                end
                8: begin
                    write_reg(REG_RANGE_MIN, CDATA_W'($urandom_range(1023)));
                    write_reg(REG_RANGE_MAX, CDATA_W'($urandom_range(1023)));
                    write_reg(REG_PWM_BASE, CDATA_W'($urandom_range(1023)));
                end
                default: begin
                    write_reg(REG_RANGE_MIN, 0); write_reg(REG_RANGE_MAX, 1023);
                    write_reg(REG_PWM_BASE, 10'h380);                   // upper bits dropped
                end
            endcase
            write_reg(REG_UNUSED, CDATA_W'($urandom_range(1023)));     // must be ignored

            case (seg % 4)
                0: begin idle_send_pct = 0;  stall_recv_pct = 0;  end
                1: begin idle_send_pct = 69; stall_recv_pct = 0;  end
                2: begin idle_send_pct = 0;  stall_recv_pct = 69; end
                default: begin idle_send_pct = 12; stall_recv_pct = 12; end
            endcase

            for (i = 0; i < SEG_ITEMS; i++) begin
                // long m_ready hold-off while beats keep coming, to back up s_
                if (seg == 2 && i == 5) hold_req++;
                it = random_beat();
                send_beat(it, 1'b0, LEVELS_OFF);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && drive_levels_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ppd_pkg.sv
rtl/core/ppd_mul.sv
rtl/core/ppd_div.sv
rtl/core/proportional_position_drive_core.sv
test/tb_top.sv
